[sv/rsn_pkg.sv]
// Shared types, constants and the stick scaling function for the RC stick
// normalizer with loss-of-signal failsafe. No dependencies.
`default_nettype none

package rsn_pkg;

   // Fixed-point format of the stick outputs
   localparam int FRACTION_BITS = 14;
   localparam int STICK_W       = FRACTION_BITS + 2;   // signed, -1.0 .. +1.0
   localparam int THROTTLE_W    = FRACTION_BITS + 1;   // unsigned, 0 .. +1.0
   localparam int Q_W           = FRACTION_BITS + 1;   // clamped magnitude

   // Field widths
   localparam int TICK_W      = 32;
   localparam int WIDTH_W     = 12;
   localparam int THRESH_W    = 12;
   localparam int TIMEOUT_W   = 16;
   localparam int CSR_DATA_W  = 16;
   localparam int REQ_DATA_W  = 96;   // 92 bits of fields, padded to bytes
   localparam int RSP_DATA_W  = 72;   // 65 bits of fields, padded to bytes

   // Pulse width centers and spans in microseconds
   localparam logic [WIDTH_W-1:0] STICK_CENTER    = 12'd1500;
   localparam logic [WIDTH_W-1:0] THROTTLE_CENTER = 12'd1000;
   localparam int RANGE_W = 10;
   localparam logic [RANGE_W-1:0] STICK_RANGE     = 10'd500;
   localparam logic [RANGE_W-1:0] THROTTLE_RANGE  = 10'd1000;

   // Reciprocal scaling: floor(x / R) == (x * ceil(2^K / R)) >> K holds
   // exactly while x * R < 2^K; x <= R << FRACTION_BITS and R < 2^10.
   localparam int RECIP_SHIFT = FRACTION_BITS + 2 * RANGE_W;
   // Both spans are at least 256, so the reciprocal fits K - 8 bits
   localparam int RECIP_W = RECIP_SHIFT - 8;
   localparam logic [RECIP_W-1:0] STICK_RECIP =
      RECIP_W'(((64'd1 << RECIP_SHIFT) + 64'd499) / 64'd500);
   localparam logic [RECIP_W-1:0] THROTTLE_RECIP =
      RECIP_W'(((64'd1 << RECIP_SHIFT) + 64'd999) / 64'd1000);
   localparam int PROD_W = RANGE_W + FRACTION_BITS + RECIP_W;

   localparam logic [Q_W-1:0] Q_ONE = Q_W'(1) << FRACTION_BITS;

   // Configuration register indexes
   typedef enum logic [0:0] {
      CSR_ARM_THRESHOLD = 1'b0,
      CSR_LOSS_TIMEOUT  = 1'b1
   } csr_index_type;

   localparam logic [THRESH_W-1:0]  ARM_THRESHOLD_RESET = 12'd1500;
   localparam logic [TIMEOUT_W-1:0] LOSS_TIMEOUT_RESET  = 16'd150;

   // One service period request
   typedef struct packed {
      logic [WIDTH_W-1:0] arm_width;
      logic [WIDTH_W-1:0] yaw_width;
      logic [WIDTH_W-1:0] throttle_width;
      logic [WIDTH_W-1:0] pitch_width;
      logic [WIDTH_W-1:0] roll_width;
      logic               frame_ok;
      logic [TICK_W-1:0]  now_ticks;
   } req_item_type;

   // One response
   typedef struct packed {
      logic                       failsafe_out;
      logic                       armed_out;
      logic signed [STICK_W-1:0]  yaw_out;
      logic [THROTTLE_W-1:0]      throttle_out;
      logic signed [STICK_W-1:0]  pitch_out;
      logic signed [STICK_W-1:0]  roll_out;
   } rsp_item_type;

   // Configuration write bundle
   typedef struct packed {
      logic                  we;
      csr_index_type         addr;
      logic [CSR_DATA_W-1:0] wdata;
   } csr_write_type;

   // ((w - center) << FRACTION_BITS) / range, truncated toward zero and
   // clamped to one; negative values go to zero unless allow_neg is set.
   function automatic logic signed [STICK_W-1:0] fit_width(
      input logic [WIDTH_W-1:0] w,
      input logic [WIDTH_W-1:0] center,
      input logic [RANGE_W-1:0] range,
      input logic [RECIP_W-1:0] recip,
      input logic               allow_neg
   );
      logic signed [WIDTH_W:0]          diff;
      logic                             neg;
      logic [WIDTH_W-1:0]               mag;
      logic [RANGE_W+FRACTION_BITS-1:0] scaled;
      logic [PROD_W-1:0]                prod;
      logic [Q_W-1:0]                   q;
      logic signed [STICK_W-1:0]        q_ext;
      diff = $signed({1'b0, w}) - $signed({1'b0, center});
      neg  = diff[WIDTH_W];
      mag  = neg ? WIDTH_W'(-diff) : WIDTH_W'(diff);
      scaled = {mag[RANGE_W-1:0], {FRACTION_BITS{1'b0}}};
      prod   = PROD_W'(scaled) * PROD_W'(recip);
      if (mag >= WIDTH_W'(range)) begin
         q = Q_ONE;
      end else begin
         q = prod[RECIP_SHIFT +: Q_W];
      end
      q_ext = $signed(STICK_W'(q));
      if (neg) begin
         fit_width = allow_neg ? -q_ext : '0;
      end else begin
         fit_width = q_ext;
      end
   endfunction

endpackage

`default_nettype wire

[sv/rsn_in_reg.sv]
// Request input register of the RC stick normalizer.
// Depends on rsn_pkg for the request item type.
`default_nettype none

module rsn_in_reg import rsn_pkg::*; (
   input  wire logic         clock,
   input  wire logic         reset,
   input  wire logic         req_valid,
   output logic              req_ready,
   input  wire req_item_type req_item,
   output logic              item_valid,
   input  wire logic         item_ready,
   output req_item_type      item
);

   logic         valid_ff, valid_in;
   req_item_type item_ff;

   // Take a new request when empty or when the held one moves on
   assign req_ready = !valid_ff || item_ready;
   assign valid_in  = req_ready ? req_valid : valid_ff;

   always_ff @(posedge clock) begin
      if (reset) begin
         valid_ff <= 1'b0;
      end else begin
         valid_ff <= valid_in;
      end
   end

   always_ff @(posedge clock) begin
      if (req_ready && req_valid) begin
         item_ff <= req_item;
      end
   end

   assign item_valid = valid_ff;
   assign item       = item_ff;

endmodule

`default_nettype wire

[sv/rsn_core.sv]
// Stick scaling, arming, failsafe state and response register of the RC stick
// normalizer. Depends on rsn_pkg for types, constants and fit_width.
`default_nettype none

module rsn_core import rsn_pkg::*; (
   input  wire logic          clock,
   input  wire logic          reset,
   input  wire csr_write_type csr,
   input  wire logic          item_valid,
   output logic               item_ready,
   input  wire req_item_type  item,
   output logic               rsp_valid,
   input  wire logic          rsp_ready,
   output rsp_item_type       rsp
);

   logic [THRESH_W-1:0]  arm_threshold_ff;
   logic [TIMEOUT_W-1:0] loss_timeout_ff;

   logic [TICK_W-1:0]         last_tick_ff, last_tick_in;
   logic signed [STICK_W-1:0] roll_ff, roll_in;
   logic signed [STICK_W-1:0] pitch_ff, pitch_in;
   logic signed [STICK_W-1:0] yaw_ff, yaw_in;
   logic [THROTTLE_W-1:0]     throttle_ff, throttle_in;
   logic                      armed_ff, armed_in;
   logic                      out_valid_ff, out_valid_in;
   rsp_item_type              rsp_ff, rsp_in;

   logic                      advance;
   logic                      fail;
   logic [TICK_W-1:0]         elapsed;
   logic signed [STICK_W-1:0] roll_fit, pitch_fit, yaw_fit, throttle_fit;

   // Configuration registers
   always_ff @(posedge clock) begin
      if (reset) begin
         arm_threshold_ff <= ARM_THRESHOLD_RESET;
         loss_timeout_ff  <= LOSS_TIMEOUT_RESET;
      end else if (csr.we) begin
         unique case (csr.addr)
            CSR_ARM_THRESHOLD: arm_threshold_ff <= csr.wdata[THRESH_W-1:0];
            CSR_LOSS_TIMEOUT:  loss_timeout_ff  <= csr.wdata[TIMEOUT_W-1:0];
            default: ;
         endcase
      end
   end

   // Move on when the response register is free or being drained
   assign item_ready = !out_valid_ff || rsp_ready;
   assign advance    = item_valid && item_ready;

   // Scaled sticks for a fresh frame
   assign roll_fit     = fit_width(item.roll_width, STICK_CENTER, STICK_RANGE,
                                   STICK_RECIP, 1'b1);
   assign pitch_fit    = fit_width(item.pitch_width, STICK_CENTER, STICK_RANGE,
                                   STICK_RECIP, 1'b1);
   assign yaw_fit      = fit_width(item.yaw_width, STICK_CENTER, STICK_RANGE,
                                   STICK_RECIP, 1'b1);
   assign throttle_fit = fit_width(item.throttle_width, THROTTLE_CENTER,
                                   THROTTLE_RANGE, THROTTLE_RECIP, 1'b0);

   // Failsafe: no frame this period and elapsed time above loss_timeout
   assign elapsed = item.now_ticks - last_tick_ff;
   assign fail    = !item.frame_ok && (elapsed > TICK_W'(loss_timeout_ff));

   // Next held state
   always_comb begin
      last_tick_in = last_tick_ff;
      roll_in      = roll_ff;
      pitch_in     = pitch_ff;
      yaw_in       = yaw_ff;
      throttle_in  = throttle_ff;
      armed_in     = armed_ff;
      if (advance) begin
         if (item.frame_ok) begin
            last_tick_in = item.now_ticks;
            roll_in      = roll_fit;
            pitch_in     = pitch_fit;
            yaw_in       = yaw_fit;
            throttle_in  = throttle_fit[THROTTLE_W-1:0];
            armed_in     = item.arm_width > arm_threshold_ff;
         end
         if (fail) begin
            roll_in     = '0;
            pitch_in    = '0;
            yaw_in      = '0;
            throttle_in = '0;
            armed_in    = 1'b0;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         last_tick_ff <= '0;
         roll_ff      <= '0;
         pitch_ff     <= '0;
         yaw_ff       <= '0;
         throttle_ff  <= '0;
         armed_ff     <= 1'b0;
      end else begin
         last_tick_ff <= last_tick_in;
         roll_ff      <= roll_in;
         pitch_ff     <= pitch_in;
         yaw_ff       <= yaw_in;
         throttle_ff  <= throttle_in;
         armed_ff     <= armed_in;
      end
   end

   // Response register
   always_comb begin
      rsp_in.roll_out     = roll_in;
      rsp_in.pitch_out    = pitch_in;
      rsp_in.throttle_out = throttle_in;
      rsp_in.yaw_out      = yaw_in;
      rsp_in.armed_out    = armed_in;
      rsp_in.failsafe_out = fail;
   end

   assign out_valid_in = advance || (out_valid_ff && !rsp_ready);

   always_ff @(posedge clock) begin
      if (reset) begin
         out_valid_ff <= 1'b0;
      end else begin
         out_valid_ff <= out_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      if (advance) begin
         rsp_ff <= rsp_in;
      end
   end

   assign rsp_valid = out_valid_ff;
   assign rsp       = rsp_ff;

   // A failsafe response carries zeroed commands and disarms
   a_fail_zero: assert property (@(posedge clock) disable iff (reset)
      (out_valid_ff && rsp_ff.failsafe_out) |->
         (rsp_ff.roll_out == '0 && rsp_ff.pitch_out == '0 && rsp_ff.yaw_out == '0
          && rsp_ff.throttle_out == '0 && !rsp_ff.armed_out))
      else $error("failsafe response with nonzero commands");

   // Held state only changes when a request is processed
   a_state_hold: assert property (@(posedge clock) disable iff (reset)
      !advance |=> ($stable(last_tick_ff) && $stable(roll_ff) && $stable(armed_ff)))
      else $error("held state changed without a request");

   // Throttle stays within zero to one
   a_throttle_range: assert property (@(posedge clock) disable iff (reset)
      throttle_ff <= THROTTLE_W'(Q_ONE))
      else $error("throttle above full scale");

   // Roll stays within minus one to one
   a_roll_range: assert property (@(posedge clock) disable iff (reset)
      (roll_ff <= $signed(STICK_W'(Q_ONE))) && (roll_ff >= -$signed(STICK_W'(Q_ONE))))
      else $error("roll out of range");

   // The last frame tick only moves on a frame
   a_tick_on_frame: assert property (@(posedge clock) disable iff (reset)
      (advance && !item.frame_ok) |=> $stable(last_tick_ff))
      else $error("frame time changed without a frame");

endmodule

`default_nettype wire

[sv/rc_stick_normalizer_failsafe.sv]
// RC stick normalizer with failsafe; depends on rsn_pkg, rsn_in_reg, rsn_core.
// A request passes the input register, then the response register, before its
// response is valid. Throughput one request per cycle while rsp_tready holds,
// one response per request; a stalled response holds the core while the input
// register takes one more request. Synchronous active-high reset clears held
// sticks, armed and last frame tick; arm_threshold to 1500, loss_timeout to 150.
`default_nettype none

module rc_stick_normalizer_failsafe import rsn_pkg::*; (
   input  wire logic                  clock,
   input  wire logic                  reset,
   // tdata: now_ticks[31:0], roll_width[43:32], pitch_width[55:44],
   //        throttle_width[67:56], yaw_width[79:68], arm_width[91:80], zero pad
   input  wire logic [REQ_DATA_W-1:0] req_tdata,
   // tuser: frame_ok
   input  wire logic                  req_tuser,
   input  wire logic                  req_tvalid,
   output logic                       req_tready,
   // tdata: roll_out[15:0], pitch_out[31:16], throttle_out[46:32],
   //        yaw_out[62:47], armed_out[63], failsafe_out[64], zero pad
   output logic [RSP_DATA_W-1:0]      rsp_tdata,
   output logic                       rsp_tvalid,
   input  wire logic                  rsp_tready,
   input  wire logic                  csr_we,
   input  wire logic                  csr_addr,
   input  wire logic [CSR_DATA_W-1:0] csr_wdata
);

   req_item_type  req_item, item;
   rsp_item_type  rsp;
   csr_write_type csr;
   logic          item_valid, item_ready;

   // Unpack the request
   always_comb begin
      req_item.now_ticks      = req_tdata[TICK_W-1:0];
      req_item.frame_ok       = req_tuser;
      req_item.roll_width     = req_tdata[TICK_W +: WIDTH_W];
      req_item.pitch_width    = req_tdata[TICK_W + WIDTH_W +: WIDTH_W];
      req_item.throttle_width = req_tdata[TICK_W + 2*WIDTH_W +: WIDTH_W];
      req_item.yaw_width      = req_tdata[TICK_W + 3*WIDTH_W +: WIDTH_W];
      req_item.arm_width      = req_tdata[TICK_W + 4*WIDTH_W +: WIDTH_W];
   end

   always_comb begin
      csr.we    = csr_we;
      csr.addr  = csr_index_type'(csr_addr);
      csr.wdata = csr_wdata;
   end

   rsn_in_reg u_in_reg (
      .clock      (clock),
      .reset      (reset),
      .req_valid  (req_tvalid),
      .req_ready  (req_tready),
      .req_item   (req_item),
      .item_valid (item_valid),
      .item_ready (item_ready),
      .item       (item)
   );

   rsn_core u_core (
      .clock      (clock),
      .reset      (reset),
      .csr        (csr),
      .item_valid (item_valid),
      .item_ready (item_ready),
      .item       (item),
      .rsp_valid  (rsp_tvalid),
      .rsp_ready  (rsp_tready),
      .rsp        (rsp)
   );

   // Pack the response, fields from the low bits up
   assign rsp_tdata = {{(RSP_DATA_W - $bits(rsp_item_type)){1'b0}}, rsp};

endmodule

`default_nettype wire
